[rtl/core/sde_pkg.sv]
package sde_pkg;

    localparam int NUM_STREAMS = 8;
    localparam int HIST_DEPTH  = 16;
    localparam int SEQ_BITS    = 16;

    // History entries are spread over banks so that one row of them is read per cycle.
    localparam int BANKS    = 4;
    localparam int BANK_W   = $clog2(BANKS);
    localparam int ROWS     = (HIST_DEPTH + BANKS - 1) / BANKS;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MEM_ROWS = NUM_STREAMS * ROWS;
    localparam int MEM_AW   = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
    localparam int CNT_W    = $clog2(HIST_DEPTH + 1);
    localparam int PTR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W    = $clog2(2 * HIST_DEPTH + BANKS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int ADDR_W = 4;

    localparam logic [4:0] HISTORY_LEN_RESET = 5'd10;

    typedef enum logic [1:0] {
        REG_MAP_VALID   = 2'd0,
        REG_MAP_TARGET  = 2'd1,
        REG_STRIP_MASK  = 2'd2,
        REG_HISTORY_LEN = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic        has_stream_tag;
        logic [2:0]  in_stream;
        logic [15:0] seq_num;
    } item_t;

    typedef struct packed {
        logic       forward;
        logic [2:0] out_stream;
        logic       rewrite_tag;
        logic       strip_tags;
    } result_t;

    typedef struct packed {
        logic [7:0]  map_valid;
        logic [23:0] map_target;
        logic [7:0]  strip_mask;
        logic [4:0]  history_len;
    } cfg_t;

    typedef struct packed {
        logic                mapped;
        logic [2:0]          target;
        logic [SEQ_BITS-1:0] seq;
        logic                strip;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

[rtl/core/sde_regs.sv]
module sde_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sde_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output sde_pkg::cfg_t             cfg
);
    import sde_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_valid   <= '0;
            cfg_reg.map_target  <= '0;
            cfg_reg.strip_mask  <= '0;
            cfg_reg.history_len <= HISTORY_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAP_VALID:   cfg_reg.map_valid   <= pwdata[7:0];
                REG_MAP_TARGET:  cfg_reg.map_target  <= pwdata[23:0];
                REG_STRIP_MASK:  cfg_reg.strip_mask  <= pwdata[7:0];
                REG_HISTORY_LEN: cfg_reg.history_len <= pwdata[4:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAP_VALID:   prdata = 32'(cfg_reg.map_valid);
            REG_MAP_TARGET:  prdata = 32'(cfg_reg.map_target);
            REG_STRIP_MASK:  prdata = 32'(cfg_reg.strip_mask);
            REG_HISTORY_LEN: prdata = 32'(cfg_reg.history_len);
        endcase
    end

endmodule

[rtl/core/sde_front.sv]
module sde_front (
    input  logic            item_valid,
    output logic            item_ready,
    input  sde_pkg::item_t  item,
    input  sde_pkg::cfg_t   cfg,
    input  sde_pkg::q_stat_t qstat,
    output logic            push,
    output sde_pkg::cmd_t   cmd
);
    import sde_pkg::*;

    logic [2:0] target;
    logic       in_ok;
    logic       tgt_ok;

    assign item_ready = !qstat.full;
    assign push       = item_valid && !qstat.full;

    assign target = cfg.map_target[3 * item.in_stream +: 3];
    assign in_ok  = item.has_stream_tag && (int'(item.in_stream) < NUM_STREAMS)
                    && cfg.map_valid[item.in_stream];
    assign tgt_ok = int'(target) < NUM_STREAMS;

    always_comb
    begin
        cmd.mapped = in_ok && tgt_ok;
        cmd.target = target;
        cmd.seq    = SEQ_BITS'(item.seq_num);
        cmd.strip  = cfg.strip_mask[target];
    end

endmodule

[rtl/core/sde_queue.sv]
module sde_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sde_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output sde_pkg::cmd_t    head_cmd,
    output sde_pkg::q_stat_t qstat
);
    import sde_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/sde_back.sv]
module sde_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sde_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  sde_pkg::cmd_t    cmd,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output sde_pkg::result_t result
);
    import sde_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cur_reg;
    cmd_t        cur_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] rd_row_reg;
    logic        rd_pend_reg;
    logic        rd_pend_next;
    logic        hit_reg;
    logic        hit_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     load_val;
    logic        load;
    logic        app_we;
    logic        out_free;

    logic [CNT_W-1:0] count_reg [NUM_STREAMS];
    logic [PTR_W-1:0] head_reg  [NUM_STREAMS];
    logic [CNT_W-1:0] cur_count;
    logic [PTR_W-1:0] cur_head;
    logic [CNT_W-1:0] eff_len;
    logic [CNT_W-1:0] new_count;
    logic [PTR_W-1:0] new_head;
    logic [SUM_W-1:0] wr_pos;

    logic [SEQ_BITS-1:0] mem [BANKS][MEM_ROWS];
    logic [SEQ_BITS-1:0] rd_data_reg [BANKS];
    logic [MEM_AW-1:0]   rd_addr;
    logic [MEM_AW-1:0]   wr_addr;
    logic [BANK_W-1:0]   wr_bank;
    logic [BANKS-1:0]    bank_match;
    logic                any_match;

    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cur_count    = count_reg[cur_reg.target];
    assign cur_head     = head_reg[cur_reg.target];
    assign eff_len      = (int'(cfg.history_len) > HIST_DEPTH) ? CNT_W'(HIST_DEPTH)
                                                              : CNT_W'(cfg.history_len);

    assign rd_addr = MEM_AW'(int'(cur_reg.target) * ROWS + int'(row_reg));
    assign wr_addr = MEM_AW'(int'(cur_reg.target) * ROWS + int'(wr_pos / BANKS));
    assign wr_bank = BANK_W'(wr_pos % BANKS);

    // An entry takes part in the search only if its ring offset from the head is below the count.
    always_comb
    begin
        logic [SUM_W-1:0] pos;
        logic [SUM_W-1:0] off;
        for (int b = 0; b < BANKS; b++)
        begin
            pos = SUM_W'(int'(rd_row_reg) * BANKS + b);
            off = pos + SUM_W'(HIST_DEPTH) - SUM_W'(cur_head);
            if (off >= SUM_W'(HIST_DEPTH))
            begin
                off = off - SUM_W'(HIST_DEPTH);
            end
            bank_match[b] = (pos < SUM_W'(HIST_DEPTH)) && (off < SUM_W'(cur_count))
                            && (rd_data_reg[b] == cur_reg.seq);
        end
    end

    assign any_match = |bank_match;

    // Append: make room if the ring is full, write behind the newest entry, then trim.
    always_comb
    begin
        logic [SUM_W-1:0] h;
        logic [SUM_W-1:0] c;
        h = SUM_W'(cur_head);
        c = SUM_W'(cur_count);
        if (c >= SUM_W'(HIST_DEPTH))
        begin
            h = h + 1'b1;
            if (h >= SUM_W'(HIST_DEPTH))
            begin
                h = h - SUM_W'(HIST_DEPTH);
            end
            c = SUM_W'(HIST_DEPTH - 1);
        end
        wr_pos = h + c;
        if (wr_pos >= SUM_W'(HIST_DEPTH))
        begin
            wr_pos = wr_pos - SUM_W'(HIST_DEPTH);
        end
        c = c + 1'b1;
        if (c > SUM_W'(eff_len))
        begin
            h = h + (c - SUM_W'(eff_len));
            if (h >= SUM_W'(HIST_DEPTH))
            begin
                h = h - SUM_W'(HIST_DEPTH);
            end
            c = SUM_W'(eff_len);
        end
        if (eff_len == '0)
        begin
            new_head  = '0;
            new_count = '0;
        end
        else
        begin
            new_head  = PTR_W'(h);
            new_count = CNT_W'(c);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        row_next     = row_reg;
        rd_pend_next = 1'b0;
        hit_next     = hit_reg || (rd_pend_reg && any_match);
        pop          = 1'b0;
        load         = 1'b0;
        load_val     = '0;
        app_we       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.mapped)
                    begin
                        if (out_free)
                        begin
                            pop              = 1'b1;
                            load             = 1'b1;
                            load_val.forward = 1'b1;
                        end
                    end
                    else
                    begin
                        pop      = 1'b1;
                        cur_next = cmd;
                        hit_next = 1'b0;
                        row_next = '0;
                        if (count_reg[cmd.target] == '0)
                        begin
                            state_next = ST_DECIDE;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                rd_pend_next = 1'b1;
                row_next     = row_reg + 1'b1;
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    load_val.out_stream = cur_reg.target;
                    if (!hit_reg)
                    begin
                        app_we               = 1'b1;
                        load_val.forward     = 1'b1;
                        load_val.rewrite_tag = !cur_reg.strip;
                        load_val.strip_tags  = cur_reg.strip;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                count_reg[s] <= '0;
                head_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            rd_pend_reg      <= rd_pend_next;
            result_valid_reg <= result_valid_next;
            if (app_we)
            begin
                count_reg[cur_reg.target] <= new_count;
                head_reg[cur_reg.target]  <= new_head;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        row_reg    <= row_next;
        rd_row_reg <= row_reg;
        hit_reg    <= hit_next;
        if (load)
        begin
            result_reg <= load_val;
        end
    end

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        always_ff @(posedge clk)
        begin
            if (app_we && (eff_len != '0) && (wr_bank == BANK_W'(b)))
            begin
                mem[b][wr_addr] <= cur_reg.seq;
            end
            rd_data_reg[b] <= mem[b][rd_addr];
        end
    end

endmodule

[rtl/core/stream_duplicate_eliminator.sv]
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_ready   item   (has_stream_tag, in_stream, seq_num)
// result    out        result_valid / result_ready result (forward, out_stream, rewrite_tag,
//                                                          strip_tags)
// config    in         APB write/read            map_valid, map_target, strip_mask, history_len
//
// A request is written into a two-entry queue at the edge that accepts it, and the back end
// can take it in the next cycle; the queue lets new requests in while the back end is busy
// or its result register waits to be taken.
// An untagged or unmapped request is settled in the idle state; a mapped one with an empty
// history goes straight to the decide state, and any other passes search, drain and decide:
// the history is read one bank row of four entries per cycle from the per-bank memories.
// Reset clears the queue, all history counts and heads, and the result valid flag.
// A stalled result blocks the back end only; the front keeps accepting until the queue fills.
module stream_duplicate_eliminator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  sde_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output sde_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sde_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import sde_pkg::*;

    cfg_t    cfg;
    cmd_t    push_cmd;
    cmd_t    head_cmd;
    q_stat_t qstat;
    logic    push;
    logic    pop;

    sde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sde_front u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg),
        .qstat      (qstat),
        .push       (push),
        .cmd        (push_cmd)
    );

    sde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    sde_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (!qstat.empty),
        .cmd          (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // The queue must never take a request while full, nor give one while empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("request popped from an empty queue");

    // A rewritten tag and stripped tags exclude each other, and a dropped packet has neither.
    a_tag_actions: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.rewrite_tag && result.strip_tags)
                         && (result.forward || (!result.rewrite_tag && !result.strip_tags)))
        else $error("inconsistent tag actions on result");

    // Accepting a request with room in the queue makes the queue non-empty next cycle.
    a_queue_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !qstat.empty)
        else $error("accepted request did not reach the queue");

endmodule
